// File: src/fbd_pkg.sv
// Shared types, constants and helpers for the Feistel frame decryptor.
`default_nettype none
package fbd_pkg;

  localparam int WORD_W    = 32;
  localparam int DATA_W    = 64;
  localparam int KEY_DEPTH = 16;
  localparam int KEY_IDX_W = 4;
  localparam int KW_W      = 5;
  localparam int ROT_W     = 5;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORDS = CFG_IDX_W'(1);

  localparam logic [KW_W-1:0] KEY_WORDS_RST = KW_W'(KEY_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_KEY    = 2'd0,
    FUNC_HEADER = 2'd1,
    FUNC_DATA   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WORD_OK   = 3'd0,
    ST_FRAME_OK  = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_TOO_SHORT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SUM,
    S_FINISH
  } state_t;

  // rotate left; a shift of zero returns the word unchanged
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

endpackage
`default_nettype wire

// File: src/fbd_if.sv
// Handshake channels: input items, result items and register writes.
`default_nettype none
interface fbd_req_if;
  logic                          valid;
  logic                          ready;
  logic [fbd_pkg::FUNC_W-1:0]    func;
  logic [fbd_pkg::KEY_IDX_W-1:0] key_index;
  logic [fbd_pkg::DATA_W-1:0]    data;
  logic                          last;

  modport source (output valid, func, key_index, data, last, input ready);
  modport sink   (input valid, func, key_index, data, last, output ready);
endinterface

interface fbd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fbd_pkg::DATA_W-1:0]   plain;
  logic [fbd_pkg::WORD_W-1:0]   check_value;
  logic [fbd_pkg::STATUS_W-1:0] status;

  modport source (output valid, plain, check_value, status, input ready);
  modport sink   (input valid, plain, check_value, status, output ready);
endinterface

interface fbd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fbd_pkg::CFG_IDX_W-1:0] index;
  logic [fbd_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/feistel_block_decrypt_with_checksum_unit.sv
// Feistel frame decryptor top level: key store, round sequencer and checksum.
// A header gives a result only when it is rejected (bad magic, too short).
// Cipher word: the rounds run in S_RUN, one round a cycle, each fed by a key store read
// issued the cycle before, then the checksum step (S_SUM) and the hand-off (S_FINISH).
// One item at a time; a result may wait in the output register while the next item runs.
// rst (synchronous) clears frame state, magic and the key store valid bits, and sets key_words to KEY_DEPTH.
`default_nettype none
module feistel_block_decrypt_with_checksum_unit #(
  parameter int ROUNDS = 16
) (
  input wire logic clk,
  input wire logic rst,
  fbd_req_if.sink  req,
  fbd_rsp_if.source rsp,
  fbd_cfg_if.sink  cfg
);

  localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int WW = fbd_pkg::WORD_W;
  localparam int KI = fbd_pkg::KEY_IDX_W;
  localparam int KD = fbd_pkg::KEY_DEPTH;
  localparam int KW = fbd_pkg::KW_W;

  fbd_pkg::state_t state, state_next;

  logic [WW-1:0]  magic;
  logic [KW-1:0]  key_words;
  logic [WW-1:0]  block_index;
  logic [WW-1:0]  running_sum;
  logic [WW-1:0]  expected_sum;
  logic           frame_open;
  logic [WW-1:0]  x, y;
  logic [RW-1:0]  rnd;
  logic [KI-1:0]  kp;
  logic           res_last;
  logic [WW-1:0]  res_check;
  fbd_pkg::status_t res_status;
  logic [KD-1:0]  key_vld;
  logic           kvld_q;
  logic           out_valid;
  logic [fbd_pkg::DATA_W-1:0]   out_plain;
  logic [WW-1:0]                out_check;
  logic [fbd_pkg::STATUS_W-1:0] out_status;

  logic           acc;
  logic           key_we;
  logic [KW-1:0]  len_eff, len_m1;
  logic [KI-1:0]  start_tab [KD];
  logic [KI-1:0]  start_idx, kp_dec, raddr;
  logic [WW-1:0]  rdata, key_word, rk, z, sum_new;
  logic [WW-1:0]  hdr_lo, hdr_hi;
  logic           out_free;

  // start key position for the top round, one entry per key length
  for (genvar g = 0; g < KD; g++) begin : g_start
    localparam int START = (ROUNDS - 1) % (g + 1);
    assign start_tab[g] = START[KI-1:0];
  end

  assign acc      = req.valid && req.ready;
  assign req.ready = (state == fbd_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign key_we   = acc && (req.func == fbd_pkg::FUNC_KEY);
  assign hdr_lo   = req.data[WW-1:0];
  assign hdr_hi   = req.data[2*WW-1:WW];
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    if (key_words == '0) begin
      len_eff = KW'(1);
    end else if (key_words > KW'(KD)) begin
      len_eff = KW'(KD);
    end else begin
      len_eff = key_words;
    end
  end

  assign len_m1    = len_eff - KW'(1);
  assign start_idx = start_tab[len_m1[KI-1:0]];
  assign kp_dec    = (kp == '0) ? len_m1[KI-1:0] : kp - KI'(1);
  assign raddr     = (state == fbd_pkg::S_IDLE) ? start_idx : kp_dec;

  fbd_ram #(.WIDTH(WW), .DEPTH(KD)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (req.key_index),
    .wdata (req.data[WW-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign key_word = kvld_q ? rdata : '0;
  assign rk       = fbd_pkg::rotl(key_word, fbd_pkg::ROT_W'(rnd)) ^ block_index;
  assign z        = fbd_pkg::rotl(rk + x, rk[fbd_pkg::ROT_W-1:0]) ^ rk ^ y;
  assign sum_new  = running_sum ^ (x + y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fbd_pkg::S_IDLE: begin
        if (acc) begin
          if (req.func == fbd_pkg::FUNC_HEADER) begin
            if (hdr_lo != magic || req.last) begin
              state_next = fbd_pkg::S_FINISH;
            end
          end else if (req.func == fbd_pkg::FUNC_DATA && frame_open) begin
            state_next = fbd_pkg::S_RUN;
          end
        end
      end
      fbd_pkg::S_RUN: begin
        if (rnd == '0) begin
          state_next = fbd_pkg::S_SUM;
        end
      end
      fbd_pkg::S_SUM:    state_next = fbd_pkg::S_FINISH;
      fbd_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = fbd_pkg::S_IDLE;
        end
      end
      default: state_next = fbd_pkg::S_IDLE;
    endcase
  end

  // registers and key store valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      magic     <= '0;
      key_words <= fbd_pkg::KEY_WORDS_RST;
      key_vld   <= '0;
      kvld_q    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == fbd_pkg::CFG_MAGIC) begin
          magic <= cfg.data;
        end else if (cfg.index == fbd_pkg::CFG_KEY_WORDS) begin
          key_words <= cfg.data[KW-1:0];
        end
      end
      if (key_we) begin
        key_vld[req.key_index] <= 1'b1;
      end
      kvld_q <= key_vld[raddr];
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open   <= 1'b0;
      block_index  <= '0;
      running_sum  <= '0;
      expected_sum <= '0;
    end else begin
      if (state == fbd_pkg::S_IDLE && acc) begin
        if (req.func == fbd_pkg::FUNC_HEADER) begin
          frame_open <= (hdr_lo == magic) && !req.last;
          if (hdr_lo == magic && !req.last) begin
            block_index  <= '0;
            running_sum  <= magic;
            expected_sum <= hdr_hi;
          end
        end else if (req.func == fbd_pkg::FUNC_DATA && frame_open) begin
          running_sum <= running_sum + (hdr_lo ^ hdr_hi);
        end
      end else if (state == fbd_pkg::S_SUM) begin
        running_sum <= sum_new;
        block_index <= block_index + WW'(1);
        if (res_last) begin
          frame_open <= 1'b0;
        end
      end
    end
  end

  // round datapath and pending result
  always_ff @(posedge clk) begin
    case (state)
      fbd_pkg::S_IDLE: begin
        if (acc && req.func == fbd_pkg::FUNC_HEADER) begin
          x          <= '0;
          y          <= '0;
          res_check  <= '0;
          res_status <= (hdr_lo != magic) ? fbd_pkg::ST_BAD_MAGIC : fbd_pkg::ST_TOO_SHORT;
        end else if (acc && req.func == fbd_pkg::FUNC_DATA) begin
          x        <= hdr_lo;
          y        <= hdr_hi;
          rnd      <= RW'(ROUNDS - 1);
          kp       <= start_idx;
          res_last <= req.last;
        end
      end
      fbd_pkg::S_RUN: begin
        x   <= z;
        y   <= x;
        rnd <= rnd - RW'(1);
        kp  <= kp_dec;
      end
      fbd_pkg::S_SUM: begin
        res_check <= sum_new;
        if (!res_last) begin
          res_status <= fbd_pkg::ST_WORD_OK;
        end else if (sum_new == expected_sum) begin
          res_status <= fbd_pkg::ST_FRAME_OK;
        end else begin
          res_status <= fbd_pkg::ST_MISMATCH;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == fbd_pkg::S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fbd_pkg::S_FINISH && out_free) begin
      out_plain  <= {y, x};
      out_check  <= res_check;
      out_status <= res_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.plain       = out_plain;
  assign rsp.check_value = out_check;
  assign rsp.status      = out_status;

  a_run_needs_frame: assert property (@(posedge clk) disable iff (rst)
    state == fbd_pkg::S_RUN |-> frame_open)
    else $error("rounds running with no open frame");

  a_data_starts_run: assert property (@(posedge clk) disable iff (rst)
    (acc && req.func == fbd_pkg::FUNC_DATA && frame_open) |=> state == fbd_pkg::S_RUN)
    else $error("cipher item did not start the rounds");

  a_last_round_sums: assert property (@(posedge clk) disable iff (rst)
    (state == fbd_pkg::S_RUN && rnd == '0) |=> state == fbd_pkg::S_SUM)
    else $error("checksum step skipped after the last round");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == fbd_pkg::S_FINISH)
    else $error("result raised outside the hand-off state");

  a_key_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    state == fbd_pkg::S_RUN |-> KW'(kp) < len_eff)
    else $error("key position beyond key length");

endmodule
`default_nettype wire

// File: src/fbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
